### rtl/core/smsd_pkg.sv
// shared types and constants for the sample mean / deviation block
// no dependencies
`timescale 1ns / 1ps

package smsd_pkg;

    localparam int MAX_SAMPLES = 128;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 8;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int MEAN_W = SAMPLE_W + FRAC_W + 1;
    localparam int D_W    = SAMPLE_W + FRAC_W + 2;
    localparam int AD_W   = SAMPLE_W + FRAC_W;
    localparam int SQ_W   = 2 * AD_W;
    localparam int VAR_W  = SQ_W;
    localparam int ACC_W  = SQ_W + $clog2(MAX_SAMPLES) + 1;

    localparam int RAM_DEPTH = 2 * MAX_SAMPLES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_COUNT_W = 8;
    localparam int OUT_SUM_W   = 23;
    localparam int OUT_MEAN_W  = 24;
    localparam int OUT_STD_W   = 24;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 80;

    // one closed set handed from the front to the back
    typedef struct packed {
        logic                    bank;
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic                    dropped;
    } t_desc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_PASS,
        ST_VAR,
        ST_ROOT,
        ST_OUT
    } t_back_state;

endpackage

### rtl/core/smsd_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module smsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/smsd_front.sv
// front end: takes sample words, writes them to the store, keeps count and sum
// depends on smsd_pkg; feeds smsd_queue and smsd_ram
`timescale 1ns / 1ps

module smsd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic signed [smsd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_last,
    input  logic                              i_q_full,
    output logic                              o_push,
    output smsd_pkg::t_desc                   o_desc,
    output logic                              o_ram_we,
    output logic [smsd_pkg::RAM_AW-1:0]       o_ram_waddr,
    output logic [smsd_pkg::SAMPLE_W-1:0]     o_ram_wdata
);
    import smsd_pkg::*;

    logic                    r_bank;
    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_drop;

    logic                    accept;
    logic                    room;
    logic [CNT_W-1:0]        n_count;
    logic signed [SUM_W-1:0] n_sum;
    logic                    n_drop;

    assign o_tready = !i_q_full;
    assign accept   = i_tvalid && !i_q_full;
    assign room     = r_count < CNT_W'(MAX_SAMPLES);

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_drop  = r_drop;
        if (room) begin
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + SUM_W'(i_sample);
        end else begin
            n_drop = 1'b1;
        end
    end

    // upper half of the store belongs to bank one
    assign o_ram_we    = accept && room;
    assign o_ram_waddr = RAM_AW'(r_count) + (r_bank ? RAM_AW'(MAX_SAMPLES) : '0);
    assign o_ram_wdata = i_sample;

    assign o_push          = accept && i_last;
    assign o_desc.bank     = r_bank;
    assign o_desc.count    = n_count;
    assign o_desc.sum      = n_sum;
    assign o_desc.dropped  = n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_bank  <= !r_bank;
                r_count <= '0;
                r_sum   <= '0;
                r_drop  <= 1'b0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_drop  <= n_drop;
            end
        end
    end

endmodule

### rtl/core/smsd_queue.sv
// short queue of closed sets between the front and the back
// depends on smsd_pkg
`timescale 1ns / 1ps

module smsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smsd_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output smsd_pkg::t_desc o_head
);
    import smsd_pkg::*;

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/smsd_div.sv
// restoring divider, one quotient bit per cycle, shared by mean and variance
// depends on smsd_pkg
`timescale 1ns / 1ps

module smsd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [smsd_pkg::ACC_W-1:0] i_num,
    input  logic [smsd_pkg::CNT_W-1:0] i_den,
    output logic                       o_done,
    output logic [smsd_pkg::ACC_W-1:0] o_quot
);
    import smsd_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_q[ACC_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[ACC_W-2:0], ge};
            r_rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ACC_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/core/smsd_back.sv
// back end: mean division, squared-difference pass, variance division, root
// depends on smsd_pkg and smsd_div; reads the sample store through smsd_ram
`timescale 1ns / 1ps

module smsd_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  smsd_pkg::t_desc                       i_q_head,
    output logic                                  o_pop,
    output logic [smsd_pkg::RAM_AW-1:0]           o_ram_raddr,
    input  logic signed [smsd_pkg::SAMPLE_W-1:0]  i_ram_rdata,
    output logic                                  o_tvalid,
    input  logic                                  i_tready,
    output logic [smsd_pkg::OUT_COUNT_W-1:0]      o_sample_count,
    output logic signed [smsd_pkg::OUT_SUM_W-1:0] o_sample_sum,
    output logic signed [smsd_pkg::OUT_MEAN_W-1:0] o_mean_q8,
    output logic [smsd_pkg::OUT_STD_W-1:0]        o_stddev_q8,
    output logic                                  o_overflowed
);
    import smsd_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic                     r_bank;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_drop;
    logic signed [MEAN_W-1:0] r_mean;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic [AD_W-1:0]          r_ad;
    logic [SQ_W-1:0]          r_sq;
    logic [ACC_W-1:0]         r_acc;
    logic [VAR_W-1:0]         r_rem;
    logic [VAR_W-1:0]         r_root;
    logic [VAR_W-1:0]         r_bit;

    logic               div_start;
    logic [ACC_W-1:0]   div_num;
    logic [CNT_W-1:0]   div_den;
    logic               div_done;
    logic [ACC_W-1:0]   div_quot;

    logic               issue;
    logic               pass_done;
    logic               root_last;
    logic [SUM_W-1:0]   head_mag;
    logic [ACC_W-1:0]   mean_num;
    logic [MEAN_W-1:0]  mean_mag;
    logic signed [D_W-1:0] diff;
    logic [D_W-1:0]     diff_abs;
    logic [VAR_W-1:0]   root_try;
    logic               root_ge;

    // mean numerator: |sum| * 256 + count / 2, rounding half away from zero
    assign head_mag = i_q_head.sum[SUM_W-1] ? SUM_W'(-i_q_head.sum) : SUM_W'(i_q_head.sum);
    assign mean_num = (ACC_W'(head_mag) << FRAC_W) + ACC_W'(i_q_head.count >> 1);
    assign mean_mag = div_quot[MEAN_W-1:0];

    assign issue     = (r_state == ST_PASS) && (r_idx < r_count);
    assign pass_done = (r_state == ST_PASS) && (r_idx == r_count) && !r_v1 && !r_v2 && !r_v3;
    assign root_last = r_bit[0];

    assign diff     = (D_W'(i_ram_rdata) <<< FRAC_W) - D_W'(r_mean);
    assign diff_abs = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);

    assign root_try = r_root + r_bit;
    assign root_ge  = r_rem >= root_try;

    smsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_MEAN;
            ST_MEAN: if (div_done) n_state = ST_PASS;
            ST_PASS: if (pass_done) n_state = ST_VAR;
            ST_VAR:  if (div_done) n_state = ST_ROOT;
            ST_ROOT: if (root_last) n_state = ST_OUT;
            ST_OUT:  if (i_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = r_acc;
        div_den   = r_count;
        o_pop     = 1'b0;
        o_tvalid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                div_start = i_q_valid;
                div_num   = mean_num;
                div_den   = i_q_head.count;
            end
            ST_PASS: begin
                div_start = pass_done;
                o_pop     = pass_done;
            end
            ST_OUT:  o_tvalid = 1'b1;
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign o_ram_raddr = RAM_AW'(r_idx) + (r_bank ? RAM_AW'(MAX_SAMPLES) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_bank  <= i_q_head.bank;
            r_count <= i_q_head.count;
            r_sum   <= i_q_head.sum;
            r_drop  <= i_q_head.dropped;
            r_idx   <= '0;
            r_acc   <= '0;
        end
        if (r_state == ST_MEAN && div_done) begin
            r_mean <= r_sum[SUM_W-1] ? MEAN_W'(-$signed(mean_mag)) : $signed(mean_mag);
        end
        if (issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (r_v1) begin
            r_ad <= diff_abs[AD_W-1:0];
        end
        if (r_v2) begin
            r_sq <= r_ad * r_ad;
        end
        if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_sq);
        end
        if (r_state == ST_VAR && div_done) begin
            r_rem  <= div_quot[VAR_W-1:0];
            r_root <= '0;
            r_bit  <= VAR_W'(1) << (VAR_W - 2);
        end
        if (r_state == ST_ROOT) begin
            if (root_ge) begin
                r_rem  <= r_rem - root_try;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sample_count = OUT_COUNT_W'(r_count);
    assign o_sample_sum   = OUT_SUM_W'(r_sum);
    assign o_mean_q8      = OUT_MEAN_W'(r_mean);
    assign o_stddev_q8    = OUT_STD_W'(r_root);
    assign o_overflowed   = r_drop;

endmodule

### rtl/core/sample_mean_stddev.sv
// top level: population mean and standard deviation of a set of samples
// depends on smsd_pkg, smsd_front, smsd_queue, smsd_ram, smsd_back
//
// input stream: one signed 16-bit sample per word, tlast closes the set.
// samples are taken one per cycle into a two-bank store (one bank per set)
// together with a count and a running sum; at most 128 samples per set are
// kept, later ones are dropped and the result's overflow flag is set.
// a closed set goes into a two-entry queue; the back end then divides for
// the rounded q8 mean (one bit per cycle), runs a pipelined pass of squared
// differences over the stored samples, divides again for the variance and
// takes a bit-pair-per-cycle integer square root.
// the result word comes after the 56-step mean division, the store read
// pass, the 56-step variance division and the 24-step root. input runs at
// one word per cycle and stalls only while the two-entry queue is full; a
// set stays in it until the back end has finished its store read pass.
// output stream: one result word per set, held until taken; a stalled
// receiver holds the back end; the front fills on until the queue is full.
// reset (synchronous, active low) clears counts, queue and sequencer;
// store contents need no clearing.

`timescale 1ns / 1ps

module sample_mean_stddev (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] sample
    input  logic [smsd_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [7:0] sample_count, [30:8] sample_sum, [54:31] mean_q8,
    // [78:55] stddev_q8, [79] zero
    output logic [smsd_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] overflowed
    output logic                                  o_m_axis_tuser
);
    import smsd_pkg::*;

    // front to queue
    logic  q_push;
    logic  q_full;
    t_desc push_desc;

    // queue to back
    logic  q_pop;
    logic  q_valid;
    t_desc q_head;

    // store ports
    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [SAMPLE_W-1:0]  ram_wdata;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;

    // result fields
    logic [OUT_COUNT_W-1:0]       res_count;
    logic signed [OUT_SUM_W-1:0]  res_sum;
    logic signed [OUT_MEAN_W-1:0] res_mean;
    logic [OUT_STD_W-1:0]         res_std;
    logic                         res_ovf;

    smsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_sample    ($signed(i_s_axis_tdata[SAMPLE_W-1:0])),
        .i_last      (i_s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (push_desc),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    smsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // sample store, two banks of MAX_SAMPLES entries
    smsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    smsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_pop          (q_pop),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    ($signed(ram_rdata)),
        .o_tvalid       (o_m_axis_tvalid),
        .i_tready       (i_m_axis_tready),
        .o_sample_count (res_count),
        .o_sample_sum   (res_sum),
        .o_mean_q8      (res_mean),
        .o_stddev_q8    (res_std),
        .o_overflowed   (res_ovf)
    );

    // pack the result word, first field lowest, one pad bit on top
    assign o_m_axis_tdata = {1'b0, res_std, res_mean, res_sum, res_count};
    assign o_m_axis_tuser = res_ovf;

endmodule
